FILE: design/joint_pair_workspace_check_assert.svh
// ----------------------------------------------------------------------------
// Joint pair workspace check assertion macros
// Shared property templates, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef JOINT_PAIR_WORKSPACE_CHECK_ASSERT_SVH
`define JOINT_PAIR_WORKSPACE_CHECK_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JPWC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define JPWC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

FILE: design/jpwc_pkg.sv
// ----------------------------------------------------------------------------
// Joint pair workspace check package
// Shared types, codes and constants of the workspace check pipeline.
// ----------------------------------------------------------------------------
package jpwc_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_SHOULDER_MIN = 3'd0,
    CFG_SHOULDER_MAX = 3'd1,
    CFG_ELBOW_MIN    = 3'd2,
    CFG_ELBOW_MAX    = 3'd3,
    CFG_ZERO_SNAP    = 3'd4
  } cfg_idx_e;

  // Failure report codes.
  typedef enum logic [1:0] {
    FAIL_NONE  = 2'd0,
    FAIL_START = 2'd1,
    FAIL_GOAL  = 2'd2
  } fail_e;

  // How a pose is judged once its trig values arrive.
  typedef enum logic [2:0] {
    KIND_PASS,
    KIND_FAIL,
    KIND_NEG,
    KIND_LOW,
    KIND_HIGH
  } kind_e;

  // Data that travels along every Horner cell.
  typedef struct packed {
    logic [29:0] x2;
    logic [29:0] x;
    logic [1:0]  quad;
    logic        swap;
  } side_t;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // Angle x = r * pi / 18000 in Q30, split as r*X_INT + (r*X_FRAC + 9000) / X_DIV.
  localparam logic [17:0] X_INT  = 18'd187403;
  localparam logic [12:0] X_FRAC = 13'd5426;
  localparam int unsigned X_DIV  = 18000;

  // Horner step divisors.
  localparam int unsigned COS_STEPS = 6;
  localparam int unsigned SIN_STEPS = 5;
  localparam int unsigned COS_DIV [COS_STEPS] = '{132, 90, 56, 30, 12, 2};
  localparam int unsigned SIN_DIV [SIN_STEPS] = '{110, 72, 42, 20, 6};

  // Cycles from a trig unit's input to its output.
  localparam int unsigned TRIG_LAT = 25;

  // Region bounds in hundredths of a degree.
  localparam logic signed [15:0] NEG_LOW   = -16'sd1800;
  localparam logic signed [15:0] NEG_ELBOW = 16'sd4200;
  localparam logic signed [15:0] LOW_TOP   = 16'sd5087;
  localparam logic signed [15:0] HIGH_LOW  = 16'sd7672;
  localparam logic signed [15:0] HIGH_TOP  = 16'sd8500;
  localparam logic signed [16:0] QUARTER_H = 17'sd4500;

  // Register reset values.
  localparam logic [15:0] RST_SHOULDER_MIN = 16'hF8F8;
  localparam logic [15:0] RST_SHOULDER_MAX = 16'd8500;
  localparam logic [15:0] RST_ELBOW_MIN    = 16'hFF9C;
  localparam logic [15:0] RST_ELBOW_MAX    = 16'd11000;
  localparam logic [9:0]  RST_ZERO_SNAP    = 10'd10;

endpackage

FILE: design/jpwc_horner_cell.sv
// ----------------------------------------------------------------------------
// Horner cell
// One Taylor step t' = 1 - ((x2 * t) >> 30) / DIV over three stages.
// ----------------------------------------------------------------------------
module jpwc_horner_cell #(
  parameter int unsigned DIV = 2
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  jpwc_pkg::side_t side_i,
  input  logic [30:0]     t_i,
  output jpwc_pkg::side_t side_o,
  output logic [30:0]     t_o
);
  import jpwc_pkg::*;

  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DIV);
  localparam logic [29:0] DIVV  = 30'(DIV);

  side_t       s1_q, s2_q, s3_q;
  logic [29:0] v1_q, v2_q;
  logic [61:0] m2_q;
  logic [30:0] t3_q;
  logic [60:0] prod1;
  logic [29:0] q0, rem;
  logic [37:0] qmul;
  logic [29:0] quo;

  // Product with the squared angle, then scaled product by the reciprocal.
  assign prod1 = {31'd0, side_i.x2} * {30'd0, t_i};
  assign q0    = m2_q[61:32];
  assign qmul  = {8'd0, q0} * 38'(DIV);
  assign rem   = v2_q - qmul[29:0];
  assign quo   = q0 + ((rem >= DIVV) ? 30'd1 : 30'd0);

  // Three stages, all held while the pipeline stalls.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= side_i;
      v1_q <= prod1[59:30];
      s2_q <= s1_q;
      v2_q <= v1_q;
      m2_q <= {32'd0, v1_q} * {30'd0, RECIP};
      s3_q <= s2_q;
      t3_q <= ONE_Q30 - {1'b0, quo};
    end
  end

  assign side_o = s3_q;
  assign t_o    = t3_q;
endmodule

FILE: design/jpwc_trig.sv
// ----------------------------------------------------------------------------
// Trig unit
// Cosine and sine of an angle in hundredths of a degree, pipelined.
// ----------------------------------------------------------------------------
module jpwc_trig #(
  parameter int unsigned TRIG_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [16:0]          ang_i,
  output logic signed [TRIG_BITS-1:0] cos_o,
  output logic signed [TRIG_BITS-1:0] sin_o
);
  import jpwc_pkg::*;

  localparam int unsigned FB    = TRIG_BITS - 2;
  localparam logic [31:0] HALF  = 32'd1 << (29 - FB);
  localparam logic [25:0] XRCP  = 26'((64'd1 << 40) / X_DIV);
  localparam logic [24:0] XDIVV = 25'(X_DIV);

  logic signed [17:0] m0, m1;
  logic [15:0] m_q;
  logic [1:0]  q2;
  logic [13:0] r2;
  logic [12:0] rr2;
  logic [1:0]  quad2_q, quad3_q, quad4_q, quad5_q;
  logic        swap2_q, swap3_q, swap4_q, swap5_q;
  logic [12:0] rr_q;
  logic [29:0] base3_q, base4_q;
  logic [24:0] p3_q, p4_q;
  logic [50:0] mq4_q;
  logic [10:0] xq0;
  logic [35:0] xqm;
  logic [24:0] xrem;
  logic [29:0] x5_q;
  logic [59:0] xsq;
  side_t       side6_q;

  // Stage 1: reduce the angle into [0, 36000).
  always_comb begin
    m0 = {ang_i[16], ang_i};
    m1 = m0;
    if (m0 < 0) begin
      m1 = m0 + 18'sd36000;
      if (m1 < 0) begin
        m1 = m1 + 18'sd36000;
      end
    end else if (m0 >= 18'sd36000) begin
      m1 = m0 - 18'sd36000;
    end
  end

  // Stage 2: quadrant and fold onto the first octant.
  always_comb begin
    if (m_q >= 16'd27000) begin
      q2 = 2'd3;
      r2 = 14'(m_q - 16'd27000);
    end else if (m_q >= 16'd18000) begin
      q2 = 2'd2;
      r2 = 14'(m_q - 16'd18000);
    end else if (m_q >= 16'd9000) begin
      q2 = 2'd1;
      r2 = 14'(m_q - 16'd9000);
    end else begin
      q2 = 2'd0;
      r2 = 14'(m_q);
    end
    rr2 = (r2 > 14'd4500) ? 13'(14'd9000 - r2) : r2[12:0];
  end

  // Stage 5: finish the division by 18000 with one correction.
  assign xq0  = mq4_q[50:40];
  assign xqm  = {25'd0, xq0} * 36'(X_DIV);
  assign xrem = p4_q - xqm[24:0];
  assign xsq  = {30'd0, x5_q} * {30'd0, x5_q};

  // Front pipeline up to the angle and its square.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q      <= m1[15:0];
      quad2_q  <= q2;
      swap2_q  <= (r2 > 14'd4500);
      rr_q     <= rr2;
      quad3_q  <= quad2_q;
      swap3_q  <= swap2_q;
      base3_q  <= 30'({17'd0, rr_q} * {12'd0, X_INT});
      p3_q     <= 25'({12'd0, rr_q} * {12'd0, X_FRAC}) + 25'd9000;
      quad4_q  <= quad3_q;
      swap4_q  <= swap3_q;
      base4_q  <= base3_q;
      p4_q     <= p3_q;
      mq4_q    <= {26'd0, p3_q} * {25'd0, XRCP};
      quad5_q  <= quad4_q;
      swap5_q  <= swap4_q;
      x5_q     <= base4_q + {19'd0, xq0} + ((xrem >= XDIVV) ? 30'd1 : 30'd0);
      side6_q  <= '{x2: xsq[59:30], x: x5_q, quad: quad5_q, swap: swap5_q};
    end
  end

  // Chains of Horner cells for cosine and sine.
  side_t       cs [COS_STEPS+1];
  logic [30:0] ct [COS_STEPS+1];
  side_t       ss [SIN_STEPS+1];
  logic [30:0] st [SIN_STEPS+1];

  assign cs[0] = side6_q;
  assign ct[0] = ONE_Q30;
  assign ss[0] = side6_q;
  assign st[0] = ONE_Q30;

  for (genvar i = 0; i < COS_STEPS; i++) begin : g_cos
    jpwc_horner_cell #(.DIV(COS_DIV[i])) u_cell (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .side_i (cs[i]),
      .t_i    (ct[i]),
      .side_o (cs[i+1]),
      .t_o    (ct[i+1])
    );
  end

  for (genvar i = 0; i < SIN_STEPS; i++) begin : g_sin
    jpwc_horner_cell #(.DIV(SIN_DIV[i])) u_cell (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .side_i (ss[i]),
      .t_i    (st[i]),
      .side_o (ss[i+1]),
      .t_o    (st[i+1])
    );
  end

  // Sine takes the final product with x, then waits for the cosine chain.
  logic [60:0] sprod;
  logic [29:0] sf_q, sd1_q, sd2_q;

  assign sprod = {31'd0, ss[SIN_STEPS].x} * {30'd0, st[SIN_STEPS]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sf_q  <= sprod[59:30];
      sd1_q <= sf_q;
      sd2_q <= sd1_q;
    end
  end

  // Round a Q30 magnitude to the output fraction, half away from zero.
  function automatic logic [TRIG_BITS-1:0] to_frac(input logic neg, input logic [30:0] mag);
    logic [31:0] sum;
    logic [31:0] rnd;
    sum = {1'b0, mag} + HALF;
    rnd = sum >> (30 - FB);
    to_frac = neg ? (~rnd[TRIG_BITS-1:0] + 1'b1) : rnd[TRIG_BITS-1:0];
  endfunction

  logic [30:0] cv, sv;
  logic [TRIG_BITS-1:0] c_d, s_d;
  logic signed [TRIG_BITS-1:0] c_q, s_q;

  // Quadrant signs, then rounding.
  always_comb begin
    side_t sd;
    sd = cs[COS_STEPS];
    cv = sd.swap ? {1'b0, sd2_q} : ct[COS_STEPS];
    sv = sd.swap ? ct[COS_STEPS] : {1'b0, sd2_q};
    unique case (sd.quad)
      2'd0: begin
        c_d = to_frac(1'b0, cv);
        s_d = to_frac(1'b0, sv);
      end
      2'd1: begin
        c_d = to_frac(1'b1, sv);
        s_d = to_frac(1'b0, cv);
      end
      2'd2: begin
        c_d = to_frac(1'b1, cv);
        s_d = to_frac(1'b1, sv);
      end
      default: begin
        c_d = to_frac(1'b0, sv);
        s_d = to_frac(1'b1, cv);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d;
      s_q <= s_d;
    end
  end

  assign cos_o = c_q;
  assign sin_o = s_q;
endmodule

FILE: design/joint_pair_workspace_check.sv
// ----------------------------------------------------------------------------
// Joint pair workspace check
// Checks a start and a goal shoulder/elbow pose against limits and regions.
// ----------------------------------------------------------------------------
// An accepted transaction passes the input stage, the trig and kind lines, then the output register.
// Throughput: one transaction per cycle while the output is not stalled; the four trig pipelines set the depth.
// The whole pipeline holds only while a result waits and the output is stalled.
// Reset clears all valid bits and loads the default joint limits.
module joint_pair_workspace_check #(
  parameter int unsigned TRIG_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: start_shoulder, start_elbow, start_present,
  //        goal_shoulder, goal_elbow, goal_present, zero pad
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,
  // tdata: request_ok, failed_pose, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import jpwc_pkg::*;

  localparam int unsigned FB = TRIG_BITS - 2;
  localparam logic signed [TRIG_BITS:0] T_DIFF =
    (TRIG_BITS+1)'(((64'd7 << (FB + 1)) + 64'd30) / 64'd60);
  localparam logic signed [TRIG_BITS:0] T_LOW =
    (TRIG_BITS+1)'(((64'd77 << (FB + 1)) + 64'd150) / 64'd300);
  localparam logic signed [TRIG_BITS:0] T_HIGH =
    (TRIG_BITS+1)'(((64'd689 << (FB + 1)) + 64'd3000) / 64'd6000);

  logic pipe_en;

  // Configuration registers.
  logic signed [15:0] sh_min_q, sh_max_q, el_min_q, el_max_q;
  logic [9:0]         snap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sh_min_q <= RST_SHOULDER_MIN;
      sh_max_q <= RST_SHOULDER_MAX;
      el_min_q <= RST_ELBOW_MIN;
      el_max_q <= RST_ELBOW_MAX;
      snap_q   <= RST_ZERO_SNAP;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SHOULDER_MIN: sh_min_q <= cfg_data_i;
        CFG_SHOULDER_MAX: sh_max_q <= cfg_data_i;
        CFG_ELBOW_MIN:    el_min_q <= cfg_data_i;
        CFG_ELBOW_MAX:    el_max_q <= cfg_data_i;
        CFG_ZERO_SNAP:    snap_q   <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // Snap an angle to zero when its magnitude is below the threshold.
  function automatic logic signed [15:0] snap(input logic signed [15:0] a,
                                              input logic [9:0] thr);
    logic [16:0] mag;
    mag = a[15] ? (17'd0 - {a[15], a}) : {1'b0, a};
    snap = (mag < {7'd0, thr}) ? 16'sd0 : a;
  endfunction

  // Input stage: snapped angles and presence flags.
  logic signed [15:0] a_q [2];
  logic signed [15:0] b_q [2];
  logic [1:0] pres_q;
  logic       vld0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (pipe_en) begin
      vld0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      a_q[0]  <= snap(s_axis_tdata[15:0], snap_q);
      b_q[0]  <= snap(s_axis_tdata[31:16], snap_q);
      pres_q[0] <= s_axis_tdata[32];
      a_q[1]  <= snap(s_axis_tdata[48:33], snap_q);
      b_q[1]  <= snap(s_axis_tdata[64:49], snap_q);
      pres_q[1] <= s_axis_tdata[65];
    end
  end

  // Classify each pose and form the trig arguments.
  kind_e kind_d [2];
  logic signed [16:0] dcos [2];
  logic signed [16:0] dsin [2];

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      logic signed [16:0] a17, b17;
      a17 = {a_q[p][15], a_q[p]};
      b17 = {b_q[p][15], b_q[p]};
      dsin[p] = QUARTER_H + a17;
      dcos[p] = a17 - b17;
      if (!pres_q[p]) begin
        kind_d[p] = KIND_PASS;
      end else if (a_q[p] < sh_min_q || a_q[p] > sh_max_q ||
                   b_q[p] < el_min_q || b_q[p] > el_max_q) begin
        kind_d[p] = KIND_FAIL;
      end else if (a_q[p] >= NEG_LOW && a_q[p] < 16'sd0) begin
        dcos[p] = b17 - a17;
        kind_d[p] = (b_q[p] >= NEG_ELBOW) ? KIND_FAIL : KIND_NEG;
      end else if (a_q[p] >= 16'sd0 && a_q[p] <= LOW_TOP) begin
        kind_d[p] = KIND_LOW;
      end else if (a_q[p] > LOW_TOP && a_q[p] < HIGH_LOW) begin
        kind_d[p] = KIND_PASS;
      end else if (a_q[p] >= HIGH_LOW && a_q[p] <= HIGH_TOP) begin
        kind_d[p] = KIND_HIGH;
      end else begin
        kind_d[p] = KIND_FAIL;
      end
    end
  end

  // Trig units: cosine of the joint difference, sine of the offset shoulder.
  logic signed [TRIG_BITS-1:0] cos_v [2];
  logic signed [TRIG_BITS-1:0] sin_v [2];

  for (genvar p = 0; p < 2; p++) begin : g_pose
    jpwc_trig #(.TRIG_BITS(TRIG_BITS)) u_trig_cos (
      .clk_i (clk_i),
      .en_i  (pipe_en),
      .ang_i (dcos[p]),
      .cos_o (cos_v[p]),
      .sin_o ()
    );
    jpwc_trig #(.TRIG_BITS(TRIG_BITS)) u_trig_sin (
      .clk_i (clk_i),
      .en_i  (pipe_en),
      .ang_i (dsin[p]),
      .cos_o (),
      .sin_o (sin_v[p])
    );
  end

  // Kind and valid lines that run beside the trig units.
  logic [TRIG_LAT-1:0] vld_q;
  kind_e kind_q [TRIG_LAT][2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[TRIG_LAT-2:0], vld0_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      kind_q[0] <= kind_d;
      for (int i = 1; i < TRIG_LAT; i++) begin
        kind_q[i] <= kind_q[i-1];
      end
    end
  end

  // Final judgement of each pose.
  logic [1:0] pose_ok;

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      logic signed [TRIG_BITS:0] c, s, cabs, diff;
      c    = {cos_v[p][TRIG_BITS-1], cos_v[p]};
      s    = {sin_v[p][TRIG_BITS-1], sin_v[p]};
      cabs = c[TRIG_BITS] ? -c : c;
      diff = c - s;
      unique case (kind_q[TRIG_LAT-1][p])
        KIND_PASS: pose_ok[p] = 1'b1;
        KIND_NEG:  pose_ok[p] = (diff <= T_DIFF) && (cabs >= T_LOW);
        KIND_LOW:  pose_ok[p] = (c >= T_LOW);
        KIND_HIGH: pose_ok[p] = (cabs >= T_HIGH);
        default:   pose_ok[p] = 1'b0;
      endcase
    end
  end

  // Output register.
  logic  out_vld_q;
  logic  ok_q;
  fail_e failed_q;

  assign pipe_en = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (pipe_en) begin
      out_vld_q <= vld_q[TRIG_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      priority if (!pose_ok[0]) begin
        ok_q     <= 1'b0;
        failed_q <= FAIL_START;
      end else if (!pose_ok[1]) begin
        ok_q     <= 1'b0;
        failed_q <= FAIL_GOAL;
      end else begin
        ok_q     <= 1'b1;
        failed_q <= FAIL_NONE;
      end
    end
  end

  assign s_axis_tready = pipe_en;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'd0, failed_q, ok_q};

  // Checks on the result encoding and on the stall behavior.
  `include "joint_pair_workspace_check_assert.svh"

  `JPWC_ASSERT_IMP(a_ok_matches_code, out_vld_q, ok_q == (failed_q == FAIL_NONE))
  `JPWC_ASSERT_IMP(a_code_legal, out_vld_q, failed_q <= FAIL_GOAL)
  `JPWC_ASSERT_NXT(a_stall_holds_pipe, !pipe_en, $stable(vld_q) && $stable(vld0_q))
endmodule
